@@ design/mbord_pkg.sv @@
`timescale 1ns / 1ps

package mbord_pkg;

   localparam int PRICE_W   = 32;
   localparam int COUNT_W   = 6;
   localparam int TOTAL_W   = 7;
   localparam int AGE_W     = 6;
   localparam int BAR_W     = 2 * PRICE_W;
   localparam int RSP_W     = 1 + 2 * PRICE_W;
   localparam int RSP_PAD_W = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd32;
   localparam logic [COUNT_W-1:0] INSIDE_RESET  = 6'd5;
   localparam logic [COUNT_W-1:0] OUTSIDE_RESET = 6'd2;

   localparam logic [CSR_IDX_W-1:0] REG_INSIDE_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTSIDE_COUNT = 1'b1;

   // start of one scan, from the request side to the scan sequencer
   typedef struct packed {
      logic                 start;
      logic                 warm;
      logic [COUNT_W-1:0]   outside;
      logic [TOTAL_W-1:0]   total;
   } scan_cmd_type;

   typedef struct packed {
      logic                 match;
      logic [PRICE_W-1:0]   range_top;
      logic [PRICE_W-1:0]   range_bottom;
   } rsp_type;

   // zero reads as one, anything above the maximum as the maximum
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 6'd1;
      end else if (v > COUNT_MAX) begin
         r = COUNT_MAX;
      end
      return r;
   endfunction

endpackage

@@ design/mbord_ring_ram.sv @@
`timescale 1ns / 1ps

module mbord_ring_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int WIDTH  = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ design/mbord_scan.sv @@
`timescale 1ns / 1ps

module mbord_scan #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbord_pkg::scan_cmd_type    cmd,
   input  logic [ADDR_W-1:0]          newest_addr,
   output logic                       busy,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr,
   input  logic [mbord_pkg::BAR_W-1:0] rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mbord_pkg::rsp_type         rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [mbord_pkg::AGE_W-1:0] issue_age_ff, issue_age_in;
   logic [mbord_pkg::AGE_W-1:0] data_age_ff;
   logic data_vld_ff;
   logic warm_ff;
   logic [mbord_pkg::COUNT_W-1:0] outside_ff;
   logic [mbord_pkg::TOTAL_W-1:0] total_ff;
   logic [mbord_pkg::PRICE_W-1:0] out_high_ff, out_low_ff, in_high_ff, in_low_ff;
   logic rsp_valid_ff;
   mbord_pkg::rsp_type rsp_ff, rsp_in;
   logic [mbord_pkg::PRICE_W-1:0] d_high, d_low;
   logic last_issue, out_free, hit;

   assign d_high = rd_data[mbord_pkg::PRICE_W-1:0];
   assign d_low  = rd_data[mbord_pkg::BAR_W-1:mbord_pkg::PRICE_W];

   assign last_issue = ({1'b0, issue_age_ff} == (total_ff - 7'd1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      issue_age_in = issue_age_ff;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in      = newest_addr;
            issue_age_in = '0;
            if (cmd.start) begin
               state_in = cmd.warm ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue_age_in = issue_age_ff + 6'd1;
            addr_in      = (addr_ff == '0) ? ADDR_W'(DEPTH - 1) : addr_ff - 1'b1;
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         data_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         data_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      issue_age_ff <= issue_age_in;
      data_age_ff  <= issue_age_ff;
      if (state_ff == ST_IDLE && cmd.start) begin
         warm_ff    <= cmd.warm;
         outside_ff <= cmd.outside;
         total_ff   <= cmd.total;
      end
   end

   // running extremes; age 0 opens the outside group, age outside_count the inside one
   always_ff @(posedge clock) begin
      if (data_vld_ff) begin
         priority if (data_age_ff == '0) begin
            out_high_ff <= d_high;
            out_low_ff  <= d_low;
         end else if (data_age_ff < outside_ff) begin
            if (d_high > out_high_ff) out_high_ff <= d_high;
            if (d_low < out_low_ff)   out_low_ff  <= d_low;
         end else if (data_age_ff == outside_ff) begin
            in_high_ff <= d_high;
            in_low_ff  <= d_low;
         end else begin
            if (d_high > in_high_ff) in_high_ff <= d_high;
            if (d_low < in_low_ff)   in_low_ff  <= d_low;
         end
      end
   end

   assign hit = !warm_ff && (in_high_ff <= out_high_ff) && (in_low_ff >= out_low_ff);

   always_comb begin
      rsp_in.match        = hit;
      rsp_in.range_top    = hit ? out_high_ff : '0;
      rsp_in.range_bottom = hit ? out_low_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN);
   assign rd_addr   = addr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ design/multi_bar_outside_range_detector_unit.sv @@
`timescale 1ns / 1ps
// Per request the sequencer runs SCAN over the inside_count + outside_count newest bars, then
//   DRAIN and DONE, or only DONE in warm-up. One request at a time, the next taken once the
//   result is loaded; the scan reads one stored bar a cycle via the ring's single read port.
// Reset (synchronous, active high): write pointer, bar count, sequencer and output valid
//   cleared, counts back to 5 and 2. Ring contents stay undefined; no clearing pass.

module multi_bar_outside_range_detector_unit #(
   parameter int WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // bar_high[31:0], bar_low[63:32]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // match[0], range_top[32:1], range_bottom[64:33], zero pad
   // configuration writes
   input  logic        csr_we,
   input  logic [mbord_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbord_pkg::COUNT_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(WINDOW);
   localparam int BS_W   = $clog2(WINDOW + 1);
   localparam int CMP_W  = (BS_W > mbord_pkg::TOTAL_W) ? BS_W : mbord_pkg::TOTAL_W;

   logic [mbord_pkg::COUNT_W-1:0] inside_count_ff, outside_count_ff;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [BS_W-1:0]   bars_seen_ff, bars_seen_in;
   logic [mbord_pkg::COUNT_W-1:0] ic, oc;
   logic [mbord_pkg::TOTAL_W-1:0] total;
   logic accept, busy, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [mbord_pkg::BAR_W-1:0] rd_data;
   mbord_pkg::scan_cmd_type cmd;
   mbord_pkg::rsp_type      rsp;

   // one request at a time; the scan owns the read port until its result is loaded
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   // configuration registers, raw value kept, clamped where used
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_count_ff  <= mbord_pkg::INSIDE_RESET;
         outside_count_ff <= mbord_pkg::OUTSIDE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mbord_pkg::REG_INSIDE_COUNT:  inside_count_ff  <= csr_wdata;
            mbord_pkg::REG_OUTSIDE_COUNT: outside_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ic    = mbord_pkg::clamp_count(inside_count_ff);
   assign oc    = mbord_pkg::clamp_count(outside_count_ff);
   assign total = {1'b0, ic} + {1'b0, oc};

   // ring pointer wraps at WINDOW, bar count saturates there
   assign wr_ptr_in    = (wr_ptr_ff == ADDR_W'(WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign bars_seen_in = (bars_seen_ff < BS_W'(WINDOW)) ? bars_seen_ff + 1'b1 : bars_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         bars_seen_ff <= '0;
      end else if (accept) begin
         wr_ptr_ff    <= wr_ptr_in;
         bars_seen_ff <= bars_seen_in;
      end
   end

   // new bar lands in the ring at the accept edge; the scan reads from the next cycle on,
   // so the newest slot is already up to date when it is read
   always_comb begin
      cmd.start   = accept;
      cmd.warm    = CMP_W'(bars_seen_in) < CMP_W'(total);
      cmd.outside = oc;
      cmd.total   = total;
   end

   mbord_ring_ram #(
      .DEPTH  (WINDOW),
      .ADDR_W (ADDR_W),
      .WIDTH  (mbord_pkg::BAR_W)
   ) u_ring (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (wr_ptr_ff),
      .wr_data    (req_tdata),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   mbord_scan #(
      .DEPTH  (WINDOW),
      .ADDR_W (ADDR_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .newest_addr (wr_ptr_ff),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = {{mbord_pkg::RSP_PAD_W{1'b0}}, rsp.range_bottom, rsp.range_top, rsp.match};

endmodule

@@ verif/tb_multi_bar_outside_range_detector_unit.sv @@
`timescale 1ns / 1ps

module tb_multi_bar_outside_range_detector_unit;

   localparam int WIN         = 64;
   localparam int ITEMS       = 1450;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT       = 1000000;

   typedef logic [mbord_pkg::PRICE_W-1:0] price_type;

   // one line of the directed plan: either a bar or a pair of count writes
   typedef enum bit {ROW_BAR, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [mbord_pkg::COUNT_W-1:0] inner;
      logic [mbord_pkg::COUNT_W-1:0] outer;
      price_type                     hi;
      price_type                     lo;
      bit                            typed;   // expectation given in the row itself
      mbord_pkg::rsp_type            want;
   } plan_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [63:0]                     req_tdata;   // bar_high[31:0], bar_low[63:32]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [71:0]                     rsp_tdata;   // match[0], range_top[32:1], range_bottom[64:33], pad
   logic                            csr_we;
   logic [mbord_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mbord_pkg::COUNT_W-1:0]   csr_wdata;

   multi_bar_outside_range_detector_unit #(.WINDOW(WIN)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the bar history and of both count registers
   // ---------------------------------------------------------------------
   price_type                     hi_hist [WIN];
   price_type                     lo_hist [WIN];
   logic [5:0]                    head      = '0;   // slot for the next bar
   int unsigned                   filled    = 0;    // bars held, saturates at WIN
   logic [mbord_pkg::COUNT_W-1:0] inner_raw = mbord_pkg::INSIDE_RESET;
   logic [mbord_pkg::COUNT_W-1:0] outer_raw = mbord_pkg::OUTSIDE_RESET;

   mbord_pkg::rsp_type verdicts [$];   // verdicts still owed by the block, oldest first
   int      faults      = 0;
   int      bars_sent   = 0;
   int      cycle_count = 0;
   bit      steady      = 1'b0;   // no idling on either side while set
   bit      hold_ask    = 1'b0;   // asks the receiver for one long hold-off

   // register value as the block uses it: zero means one, over 32 means 32
   function automatic int unsigned eff_count(input logic [mbord_pkg::COUNT_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > mbord_pkg::COUNT_MAX) return 32'(mbord_pkg::COUNT_MAX);
      return 32'(raw);
   endfunction

   // store the bar, then compare the outside group (newest bars) with the
   // inside group just before it
   function automatic mbord_pkg::rsp_type judge_bar(input price_type h, input price_type l);
      mbord_pkg::rsp_type verdict;
      int unsigned        oc;
      int unsigned        span;
      price_type          oh, ol, ih, il;
      logic [5:0]         pos;
      verdict = '0;
      hi_hist[head] = h;
      lo_hist[head] = l;
      head = head + 6'd1;
      if (filled < WIN) filled++;
      oc   = eff_count(outer_raw);
      span = eff_count(inner_raw) + oc;
      if (filled < span) return verdict;   // still warming up
      pos = head - 6'd1;
      oh  = hi_hist[pos];
      ol  = lo_hist[pos];
      ih  = '0;
      il  = '0;
      for (int age = 1; age < span; age++) begin
         pos = head - 6'd1 - 6'(age);
         if (age < oc) begin
            if (hi_hist[pos] > oh) oh = hi_hist[pos];
            if (lo_hist[pos] < ol) ol = lo_hist[pos];
         end else if (age == oc) begin
            ih = hi_hist[pos];
            il = lo_hist[pos];
         end else begin
            if (hi_hist[pos] > ih) ih = hi_hist[pos];
            if (lo_hist[pos] < il) il = lo_hist[pos];
         end
      end
      if (ih <= oh && il >= ol) verdict = '{1'b1, oh, ol};
      return verdict;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one bar; on acceptance the predictor runs and the verdict is
   // queued, or the one typed into the plan where given.  tvalid is left
   // high so back-to-back requests need no second assignment.
   task automatic offer_bar(input price_type h, input price_type l, input bit typed,
                            input mbord_pkg::rsp_type given);
      int                 gap;
      mbord_pkg::rsp_type calc;
      gap = idle_len();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {l, h};
      do @(posedge clock); while (!req_tready);
      calc = judge_bar(h, l);
      verdicts.push_back(typed ? given : calc);
      bars_sent++;
   endtask

   // Writes both counts once the block has drained; every request yields a
   // result, so an empty verdict queue means the block is idle.
   task automatic program_counts(input logic [mbord_pkg::COUNT_W-1:0] inner,
                                 input logic [mbord_pkg::COUNT_W-1:0] outer);
      req_tvalid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= mbord_pkg::REG_INSIDE_COUNT;
      csr_wdata <= inner;
      @(posedge clock);
      csr_index <= mbord_pkg::REG_OUTSIDE_COUNT;
      csr_wdata <= outer;
      @(posedge clock);
      csr_we    <= 1'b0;
      inner_raw = inner;
      outer_raw = outer;
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready pattern, with one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_pacer
      int pause;
      pause = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            // block fills up behind this and must back-pressure requests
            hold_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (pause != 0) begin
            rsp_tready <= 1'b0;
            pause--;
         end else begin
            rsp_tready <= 1'b1;
            pause = idle_len();
         end
      end
   end

   // field-by-field check of each accepted result against the oldest verdict
   always @(posedge clock) begin : rsp_check
      mbord_pkg::rsp_type want;
      mbord_pkg::rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.match        = rsp_tdata[0];
         got.range_top    = rsp_tdata[32:1];
         got.range_bottom = rsp_tdata[64:33];
         if (verdicts.size() == 0) begin
            $error("unexpected result, nothing outstanding: %h", rsp_tdata);
            faults++;
         end else begin
            want = verdicts.pop_front();
            if (got.match !== want.match) begin
               $error("match: expected %0d, got %0d", want.match, got.match);
               faults++;
            end
            if (got.range_top !== want.range_top) begin
               $error("range_top: expected %h, got %h", want.range_top, got.range_top);
               faults++;
            end
            if (got.range_bottom !== want.range_bottom) begin
               $error("range_bottom: expected %h, got %h",
                      want.range_bottom, got.range_bottom);
               faults++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed plan.  Typed rows: warm-up, counts of zero, price extremes,
   // high below low, equal ranges.  Other bar rows go through the predictor.
   // ---------------------------------------------------------------------
   plan_row_type plan [19] = '{
      // first bar after reset: counts 5 and 2, so still warming up
      '{ROW_BAR, 6'd0,  6'd0,  32'd10,         32'd5,          1'b1, '{1'b0, 32'd0, 32'd0}},
      // both counts zero, read as one each
      '{ROW_CFG, 6'd0,  6'd0,  32'd0,          32'd0,          1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd20,         32'd2,          1'b1, '{1'b1, 32'd20, 32'd2}},
      '{ROW_BAR, 6'd0,  6'd0,  32'hFFFF_FFFF,  32'd0,          1'b1,
        '{1'b1, 32'hFFFF_FFFF, 32'd0}},
      // high below low, outside loses
      '{ROW_BAR, 6'd0,  6'd0,  32'd0,          32'hFFFF_FFFF,  1'b1, '{1'b0, 32'd0, 32'd0}},
      // identical ranges count as contained
      '{ROW_BAR, 6'd0,  6'd0,  32'd0,          32'hFFFF_FFFF,  1'b1,
        '{1'b1, 32'd0, 32'hFFFF_FFFF}},
      '{ROW_BAR, 6'd0,  6'd0,  32'd7,          32'd7,          1'b1, '{1'b1, 32'd7, 32'd7}},
      '{ROW_CFG, 6'd3,  6'd2,  32'd0,          32'd0,          1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd100,        32'd90,         1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd105,        32'd95,         1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd130,        32'd60,         1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd120,        32'd70,         1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd100,        32'd80,         1'b0, '0},
      // counts above 32 clip to 32: 64 bars needed, history too short
      '{ROW_CFG, 6'd63, 6'd33, 32'd0,          32'd0,          1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd5,          32'd4,          1'b1, '{1'b0, 32'd0, 32'd0}},
      '{ROW_BAR, 6'd0,  6'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{1'b0, 32'd0, 32'd0}},
      '{ROW_CFG, 6'd32, 6'd1,  32'd0,          32'd0,          1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'd1,          32'd0,          1'b0, '0},
      '{ROW_BAR, 6'd0,  6'd0,  32'h8000_0000,  32'h7FFF_FFFF,  1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int                            phase;
      int                            run;
      int                            r;
      price_type                     h, l, prev_h, prev_l, mid;
      logic [mbord_pkg::COUNT_W-1:0] inner, outer;
      logic [mbord_pkg::COUNT_W-1:0] edges [5];

      edges = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= mbord_pkg::REG_INSIDE_COUNT;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) program_counts(plan[i].inner, plan[i].outer);
         else offer_bar(plan[i].hi, plan[i].lo, plan[i].typed, plan[i].want);
      end

      // Random phases.  Bars follow a drifting mid price with narrow and wide
      // ranges and repeats, so the outside group often brackets the inside
      // group; the rest is raw noise and rail values.
      phase  = 0;
      prev_h = '0;
      prev_l = '0;
      while (bars_sent < ITEMS) begin
         if (phase == 0) begin
            inner = 6'd63;   // full ring: 32 + 32
            outer = 6'd63;
         end else if (phase == 1) begin
            inner = 6'd0;
            outer = 6'd33;
         end else if (phase == 2 || phase == 7) begin
            inner = 6'($urandom_range(1, 3));
            outer = 6'($urandom_range(1, 3));
         end else begin
            inner = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 4)]
                                                : 6'($urandom_range(0, 63));
            outer = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 4)]
                                                : 6'($urandom_range(0, 63));
         end
         program_counts(inner, outer);
         steady = (phase % 5 == 4);
         // receiver stalls for a long stretch while requests keep coming
         if (phase == 2 || phase == 7) hold_ask = 1'b1;
         mid = $urandom_range(32'h0010_0000, 32'hFFE0_0000);
         run = $urandom_range(40, 160);
         if (run > ITEMS - bars_sent) run = ITEMS - bars_sent;
         repeat (run) begin
            mid = mid + $urandom_range(0, 400) - 200;
            r   = $urandom_range(0, 99);
            if (r < 60) begin
               h = mid + $urandom_range(0, 1500);
               l = mid - $urandom_range(0, 1500);
            end else if (r < 75) begin
               h = mid + $urandom_range(0, 30000);
               l = mid - $urandom_range(0, 30000);
            end else if (r < 85) begin
               h = prev_h;
               l = prev_l;
            end else if (r < 95) begin
               h = $urandom;
               l = $urandom;
            end else begin
               h = $urandom_range(0, 1) ? '1 : '0;
               l = $urandom_range(0, 1) ? '1 : '0;
            end
            prev_h = h;
            prev_l = l;
            offer_bar(h, l, 1'b0, '0);
         end
         phase++;
      end

      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
      // anything stray from the longest scan shows up within this wait
      repeat (100) @(posedge clock);
      if (faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/mbord_pkg.sv
design/mbord_ring_ram.sv
design/mbord_scan.sv
design/multi_bar_outside_range_detector_unit.sv
verif/tb_multi_bar_outside_range_detector_unit.sv
